### rtl/core/pager_message_line_buffer_assert.svh
// ----------------------------------------------------------------------------
// Pager message line buffer assertion macros
// Implication checks, same cycle and next cycle, gated by reset.
// ----------------------------------------------------------------------------
`ifndef PAGER_MESSAGE_LINE_BUFFER_ASSERT_SVH
`define PAGER_MESSAGE_LINE_BUFFER_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define PMLB_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pmlb: implication check failed");

// antecedent implies consequent in the next cycle
`define PMLB_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pmlb: next-cycle check failed");

`endif

### rtl/core/pmlb_pkg.sv
// ----------------------------------------------------------------------------
// Pager message line buffer package
// Transaction types, command codes and character constants.
// ----------------------------------------------------------------------------
package pmlb_pkg;

  localparam int unsigned OUT_ROW_W  = 64;
  localparam int unsigned PAGE_ROW_W = 5;

  localparam logic [7:0] END_OF_MESSAGE = 8'h00;
  localparam logic [7:0] END_OF_ROW     = 8'h0a;

  typedef enum logic {
    CMD_CHAR    = 1'b0,
    CMD_ADVANCE = 1'b1
  } pmlb_cmd_t;

  typedef struct packed {
    pmlb_cmd_t  command;
    logic [7:0] char_byte;
  } pmlb_item_t;

  typedef struct packed {
    logic [OUT_ROW_W-1:0]  top_row;
    logic [OUT_ROW_W-1:0]  bottom_row;
    logic                  byte_dropped;
    logic                  message_done;
    logic [PAGE_ROW_W-1:0] page_row;
  } pmlb_result_t;

  typedef struct packed {
    logic byte_dropped;
    logic message_done;
  } pmlb_flags_t;

endpackage

### rtl/core/pmlb_ctrl.sv
// ----------------------------------------------------------------------------
// Pager message line buffer pointer control
// Read/write row and character position update, store write request.
// ----------------------------------------------------------------------------
module pmlb_ctrl #(
  parameter int unsigned ROWS      = 32,
  parameter int unsigned ROW_CHARS = 8,
  parameter int unsigned ROW_W     = $clog2(ROWS),
  parameter int unsigned CPOS_W    = (ROW_CHARS > 1) ? $clog2(ROW_CHARS) : 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  pmlb_pkg::pmlb_item_t item,
  output logic                 wr_en,
  output logic [ROW_W-1:0]     wr_row,
  output logic [CPOS_W-1:0]    wr_lane,
  output logic [7:0]           wr_byte,
  output logic [ROW_W-1:0]     rd_row_a,
  output logic [ROW_W-1:0]     rd_row_b,
  output pmlb_pkg::pmlb_flags_t flags
);
  import pmlb_pkg::*;

  localparam int unsigned RW1 = ROW_W + 1;
  localparam logic [RW1-1:0] ROWS_L = RW1'(ROWS);
  localparam logic [CPOS_W-1:0] LAST_POS = CPOS_W'(ROW_CHARS - 1);

  logic [ROW_W-1:0]  read_row, read_row_next;
  logic [ROW_W-1:0]  write_row, write_row_next;
  logic [CPOS_W-1:0] char_pos, char_pos_next;
  logic [RW1-1:0]    wr_inc, wr_even, adv_sum, adv_clamp, adv_pick, rd_inc;
  logic [ROW_W-1:0]  wr_step, wr_page, rd_adv;
  logic              full, is_char;

  always_comb begin
    wr_inc    = {1'b0, write_row} + RW1'(1);
    wr_step   = (wr_inc >= ROWS_L) ? ROW_W'(wr_inc - ROWS_L) : wr_inc[ROW_W-1:0];
    wr_even   = ({1'b0, write_row} | RW1'(1)) + RW1'(1);
    wr_page   = (wr_even >= ROWS_L) ? ROW_W'(wr_even - ROWS_L) : wr_even[ROW_W-1:0];
    adv_sum   = {1'b0, read_row} + RW1'(2);
    adv_clamp = {1'b0, write_row} + RW1'(write_row[0]);
    adv_pick  = (adv_sum > wr_inc) ? adv_clamp : adv_sum;
    rd_adv    = (adv_pick >= ROWS_L) ? ROW_W'(adv_pick - ROWS_L) : adv_pick[ROW_W-1:0];
    full      = (wr_step == read_row);
    is_char   = (item.command == CMD_CHAR);
  end

  always_comb begin
    read_row_next      = read_row;
    write_row_next     = write_row;
    char_pos_next      = char_pos;
    wr_en              = 1'b0;
    wr_byte            = item.char_byte;
    flags.byte_dropped = 1'b0;
    flags.message_done = 1'b0;
    if (accept) begin
      if (!is_char) begin
        read_row_next = rd_adv;
      end else if (full) begin
        flags.byte_dropped = 1'b1;
      end else begin
        wr_en = 1'b1;
        case (item.char_byte)
          END_OF_MESSAGE: begin
            wr_byte            = END_OF_MESSAGE;
            write_row_next     = wr_page;
            char_pos_next      = '0;
            flags.message_done = 1'b1;
          end
          END_OF_ROW: begin
            wr_byte        = END_OF_MESSAGE;
            write_row_next = wr_step;
            char_pos_next  = '0;
          end
          default: begin
            if (char_pos == LAST_POS) begin
              char_pos_next  = '0;
              write_row_next = wr_step;
            end else begin
              char_pos_next = char_pos + CPOS_W'(1);
            end
          end
        endcase
      end
    end
  end

  always_comb begin
    wr_row   = write_row;
    wr_lane  = char_pos;
    rd_row_a = read_row_next;
    rd_inc   = {1'b0, read_row_next} + RW1'(1);
    rd_row_b = (rd_inc >= ROWS_L) ? ROW_W'(rd_inc - ROWS_L) : rd_inc[ROW_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      read_row  <= '0;
      write_row <= '0;
      char_pos  <= '0;
    end else begin
      read_row  <= read_row_next;
      write_row <= write_row_next;
      char_pos  <= char_pos_next;
    end
  end

`include "pager_message_line_buffer_assert.svh"

  `PMLB_ASSERT_IMPL(a_read_row_range, clk, rst, 1'b1, RW1'(read_row) < ROWS_L)
  `PMLB_ASSERT_IMPL(a_write_row_range, clk, rst, 1'b1, RW1'(write_row) < ROWS_L)
  `PMLB_ASSERT_NEXT(a_drop_holds, clk, rst, accept && is_char && full, $stable(write_row) && $stable(char_pos) && $stable(read_row))
  `PMLB_ASSERT_NEXT(a_done_row_start, clk, rst, flags.message_done, char_pos == '0)

endmodule

### rtl/core/pmlb_row_mem.sv
// ----------------------------------------------------------------------------
// Pager message line buffer row store
// Row-wide memory, byte lane write, two registered read ports, row valid bits.
// ----------------------------------------------------------------------------
module pmlb_row_mem #(
  parameter int unsigned ROWS      = 32,
  parameter int unsigned ROW_CHARS = 8,
  parameter int unsigned ROW_W     = $clog2(ROWS),
  parameter int unsigned CPOS_W    = (ROW_CHARS > 1) ? $clog2(ROW_CHARS) : 1,
  parameter int unsigned DATA_W    = ROW_CHARS * 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  logic [ROW_W-1:0]  wr_row,
  input  logic [CPOS_W-1:0] wr_lane,
  input  logic [7:0]        wr_byte,
  input  logic              rd_en,
  input  logic [ROW_W-1:0]  rd_row_a,
  input  logic [ROW_W-1:0]  rd_row_b,
  output logic [DATA_W-1:0] row_a,
  output logic [DATA_W-1:0] row_b
);
  logic [DATA_W-1:0] mem [ROWS];
  logic [ROWS-1:0]   row_valid;
  logic [DATA_W-1:0] rd_data_a, rd_data_b;
  logic              rd_vld_a, rd_vld_b;

  // first write to a row clears the other lanes
  always_ff @(posedge clk) begin
    if (wr_en) begin
      for (int i = 0; i < ROW_CHARS; i++) begin
        if (wr_lane == CPOS_W'(i)) begin
          mem[wr_row][i*8 +: 8] <= wr_byte;
        end else if (!row_valid[wr_row]) begin
          mem[wr_row][i*8 +: 8] <= 8'h00;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (wr_en) begin
      row_valid[wr_row] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_a <= mem[rd_row_a];
      rd_data_b <= mem[rd_row_b];
      rd_vld_a  <= row_valid[rd_row_a];
      rd_vld_b  <= row_valid[rd_row_b];
    end
  end

  assign row_a = rd_vld_a ? rd_data_a : '0;
  assign row_b = rd_vld_b ? rd_data_b : '0;

endmodule

### rtl/core/pmlb_out.sv
// ----------------------------------------------------------------------------
// Pager message line buffer result stage
// Write bypass, terminator masking and result register with handshake.
// ----------------------------------------------------------------------------
module pmlb_out #(
  parameter int unsigned ROW_CHARS = 8,
  parameter int unsigned ROW_W     = 5,
  parameter int unsigned CPOS_W    = (ROW_CHARS > 1) ? $clog2(ROW_CHARS) : 1,
  parameter int unsigned DATA_W    = ROW_CHARS * 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   accept,
  input  logic                   wr_en,
  input  logic [ROW_W-1:0]       wr_row,
  input  logic [CPOS_W-1:0]      wr_lane,
  input  logic [7:0]             wr_byte,
  input  logic [ROW_W-1:0]       rd_row_a,
  input  logic [ROW_W-1:0]       rd_row_b,
  input  pmlb_pkg::pmlb_flags_t  flags,
  input  logic [DATA_W-1:0]      row_a,
  input  logic [DATA_W-1:0]      row_b,
  output logic                   ready,
  output pmlb_pkg::pmlb_result_t result,
  output logic                   result_valid,
  input  logic                   result_stall
);
  import pmlb_pkg::*;

  localparam int unsigned EXT_W = ROW_W + PAGE_ROW_W;

  logic                  s1_valid, hit_a, hit_b, advance;
  logic [CPOS_W-1:0]     byp_lane;
  logic [7:0]            byp_byte;
  pmlb_flags_t           s1_flags;
  logic [PAGE_ROW_W-1:0] s1_page;
  logic [EXT_W-1:0]      page_ext;
  logic [DATA_W-1:0]     fixed_a, fixed_b;
  pmlb_result_t          result_next;

  function automatic logic [OUT_ROW_W-1:0] mask_row(input logic [OUT_ROW_W-1:0] row);
    logic [OUT_ROW_W-1:0] m;
    logic                 ended;
    m     = '0;
    ended = 1'b0;
    for (int i = 0; i < OUT_ROW_W / 8; i++) begin
      if (row[i*8 +: 8] == END_OF_MESSAGE) ended = 1'b1;
      if (!ended) m[i*8 +: 8] = row[i*8 +: 8];
    end
    return m;
  endfunction

  assign advance  = s1_valid && (!result_valid || !result_stall);
  assign ready    = !s1_valid || !result_valid || !result_stall;
  assign page_ext = EXT_W'(rd_row_a);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hit_a    <= wr_en && (wr_row == rd_row_a);
      hit_b    <= wr_en && (wr_row == rd_row_b);
      byp_lane <= wr_lane;
      byp_byte <= wr_byte;
      s1_flags <= flags;
      s1_page  <= page_ext[PAGE_ROW_W-1:0];
    end
  end

  always_comb begin
    fixed_a = row_a;
    fixed_b = row_b;
    for (int i = 0; i < ROW_CHARS; i++) begin
      if (hit_a && byp_lane == CPOS_W'(i)) fixed_a[i*8 +: 8] = byp_byte;
      if (hit_b && byp_lane == CPOS_W'(i)) fixed_b[i*8 +: 8] = byp_byte;
    end
    result_next.top_row      = mask_row(OUT_ROW_W'(fixed_a));
    result_next.bottom_row   = mask_row(OUT_ROW_W'(fixed_b));
    result_next.byte_dropped = s1_flags.byte_dropped;
    result_next.message_done = s1_flags.message_done;
    result_next.page_row     = s1_page;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= result_next;
    end
  end

endmodule

### rtl/core/pager_message_line_buffer.sv
// ----------------------------------------------------------------------------
// Pager message line buffer: circular two-row page store for received text
// Items pass the read and bypass registers, then a result register held by stall.
// Throughput: one item per cycle absent result stalls, set by input and result regs.
// Reset: pointers zero, row valid bits cleared at once, input stalled during rst.
// ----------------------------------------------------------------------------
module pager_message_line_buffer #(
  parameter int unsigned ROWS      = 32,
  parameter int unsigned ROW_CHARS = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  pmlb_pkg::pmlb_item_t   item,
  input  logic                   item_valid,
  output logic                   item_stall,
  output pmlb_pkg::pmlb_result_t result,
  output logic                   result_valid,
  input  logic                   result_stall
);
  import pmlb_pkg::*;

  localparam int unsigned ROW_W  = $clog2(ROWS);
  localparam int unsigned CPOS_W = (ROW_CHARS > 1) ? $clog2(ROW_CHARS) : 1;
  localparam int unsigned DATA_W = ROW_CHARS * 8;

  logic              ready, accept, wr_en;
  logic [ROW_W-1:0]  wr_row, rd_row_a, rd_row_b;
  logic [CPOS_W-1:0] wr_lane;
  logic [7:0]        wr_byte;
  logic [DATA_W-1:0] row_a, row_b;
  pmlb_flags_t       flags;

  assign item_stall = rst || !ready;
  assign accept     = item_valid && !item_stall;

  pmlb_ctrl #(
    .ROWS      (ROWS),
    .ROW_CHARS (ROW_CHARS),
    .ROW_W     (ROW_W),
    .CPOS_W    (CPOS_W)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .item     (item),
    .wr_en    (wr_en),
    .wr_row   (wr_row),
    .wr_lane  (wr_lane),
    .wr_byte  (wr_byte),
    .rd_row_a (rd_row_a),
    .rd_row_b (rd_row_b),
    .flags    (flags)
  );

  pmlb_row_mem #(
    .ROWS      (ROWS),
    .ROW_CHARS (ROW_CHARS),
    .ROW_W     (ROW_W),
    .CPOS_W    (CPOS_W),
    .DATA_W    (DATA_W)
  ) u_row_mem (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_row   (wr_row),
    .wr_lane  (wr_lane),
    .wr_byte  (wr_byte),
    .rd_en    (accept),
    .rd_row_a (rd_row_a),
    .rd_row_b (rd_row_b),
    .row_a    (row_a),
    .row_b    (row_b)
  );

  pmlb_out #(
    .ROW_CHARS (ROW_CHARS),
    .ROW_W     (ROW_W),
    .CPOS_W    (CPOS_W),
    .DATA_W    (DATA_W)
  ) u_out (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .wr_en        (wr_en),
    .wr_row       (wr_row),
    .wr_lane      (wr_lane),
    .wr_byte      (wr_byte),
    .rd_row_a     (rd_row_a),
    .rd_row_b     (rd_row_b),
    .flags        (flags),
    .row_a        (row_a),
    .row_b        (row_b),
    .ready        (ready),
    .result       (result),
    .result_valid (result_valid),
    .result_stall (result_stall)
  );

endmodule

### tb/pager_message_line_buffer_tb.sv
// ----------------------------------------------------------------------------
// Pager message line buffer testbench
// Drives character and page-advance transactions through the valid/stall
// input, predicts every page view in a local copy of the row store and
// pointers, and compares each result field against the oldest prediction.
// A short directed table opens the run, then random messages follow.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pager_message_line_buffer_tb;
  import pmlb_pkg::*;

  localparam int RAND_ITEMS   = 900;
  localparam int BLOCK_ITEMS  = 180;
  localparam int HOLD_CYCLES  = 80;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 10;
  localparam int IDLE_PCT     = 38;

  typedef struct packed {
    pmlb_item_t   it;
    bit           typed;
    pmlb_result_t view;
  } dir_row_t;

  logic         clk = 1'b0;
  logic         rst;
  pmlb_item_t   item;
  logic         item_valid;
  logic         item_stall;
  pmlb_result_t result;
  logic         result_valid;
  logic         result_stall;

  logic [7:0]   line_mem [32][8];
  logic [4:0]   rd_row;
  logic [4:0]   wr_row;
  logic [2:0]   col_pos;

  pmlb_result_t page_view_q [$];
  pmlb_result_t exp_view;
  dir_row_t     dir_tab [$];
  int           mismatches   = 0;
  int           quiet_cycles = 0;
  bit           idle_on      = 1'b1;
  bit           hold_req     = 1'b0;

  pager_message_line_buffer dut (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result       (result),
    .result_valid (result_valid),
    .result_stall (result_stall)
  );

  always #5 clk = ~clk;

  // displayed characters stop at the first terminator
  function automatic logic [63:0] row_image(logic [4:0] r);
    logic [63:0] v;
    bit          hit;
    v   = '0;
    hit = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (line_mem[r][i] == 8'h00) hit = 1'b1;
      if (!hit) v[8*i +: 8] = line_mem[r][i];
    end
    return v;
  endfunction

  function automatic pmlb_result_t next_page_view(pmlb_item_t it);
    pmlb_result_t r;
    int           nxt;
    r = '0;
    if (it.command == CMD_CHAR) begin
      if (5'(wr_row + 5'd1) == rd_row) begin
        r.byte_dropped = 1'b1;
      end else if (it.char_byte == END_OF_MESSAGE) begin
        line_mem[wr_row][col_pos] = 8'h00;
        wr_row       = wr_row + (wr_row[0] ? 5'd1 : 5'd2);
        col_pos      = '0;
        r.message_done = 1'b1;
      end else if (it.char_byte == END_OF_ROW) begin
        line_mem[wr_row][col_pos] = 8'h00;
        wr_row  = wr_row + 5'd1;
        col_pos = '0;
      end else begin
        line_mem[wr_row][col_pos] = it.char_byte;
        col_pos = col_pos + 3'd1;
        if (col_pos == 3'd0) wr_row = wr_row + 5'd1;
      end
    end else begin
      // clamp ignores wrap
      nxt = int'(rd_row) + 2;
      if (nxt > int'(wr_row) + 1) nxt = int'(wr_row) + int'(wr_row[0]);
      rd_row = 5'(nxt);
    end
    r.top_row    = row_image(rd_row);
    r.bottom_row = row_image(rd_row + 5'd1);
    r.page_row   = rd_row;
    return r;
  endfunction

  function automatic dir_row_t pred_row(pmlb_cmd_t c, logic [7:0] b);
    dir_row_t r;
    r = '0;
    r.it.command   = c;
    r.it.char_byte = b;
    return r;
  endfunction

  function automatic dir_row_t typed_row(pmlb_cmd_t c, logic [7:0] b, logic [63:0] top,
                                         logic [63:0] bot, logic dr, logic dn,
                                         logic [4:0] pg);
    dir_row_t r;
    r = pred_row(c, b);
    r.typed             = 1'b1;
    r.view.top_row      = top;
    r.view.bottom_row   = bot;
    r.view.byte_dropped = dr;
    r.view.message_done = dn;
    r.view.page_row     = pg;
    return r;
  endfunction

  task automatic send_item(pmlb_item_t it, bit typed, pmlb_result_t view);
    pmlb_result_t pred;
    while (idle_on && $urandom_range(99) < IDLE_PCT) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item       <= it;
    item_valid <= 1'b1;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    pred = next_page_view(it);
    page_view_q.push_back(typed ? view : pred);
  endtask

  initial begin
    result_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        result_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      result_stall <= idle_on && ($urandom_range(99) < IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (page_view_q.size() == 0) begin
        $error("result transaction with no prediction pending");
        mismatches++;
      end else begin
        exp_view = page_view_q.pop_front();
        if (result.top_row !== exp_view.top_row) begin
          $error("top_row: expected %h, got %h", exp_view.top_row, result.top_row);
          mismatches++;
        end
        if (result.bottom_row !== exp_view.bottom_row) begin
          $error("bottom_row: expected %h, got %h", exp_view.bottom_row, result.bottom_row);
          mismatches++;
        end
        if (result.byte_dropped !== exp_view.byte_dropped) begin
          $error("byte_dropped: expected %b, got %b", exp_view.byte_dropped,
                 result.byte_dropped);
          mismatches++;
        end
        if (result.message_done !== exp_view.message_done) begin
          $error("message_done: expected %b, got %b", exp_view.message_done,
                 result.message_done);
          mismatches++;
        end
        if (result.page_row !== exp_view.page_row) begin
          $error("page_row: expected %0d, got %0d", exp_view.page_row, result.page_row);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == STALL_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    pmlb_item_t   it;
    pmlb_result_t none;
    int           sent;
    int           msg_left;
    int           adv_pct;
    int           roll;
    int           adv_mix [5];

    rst        <= 1'b1;
    item       <= '0;
    item_valid <= 1'b0;
    none       = '0;
    sent       = 0;
    msg_left   = 0;
    adv_pct    = 0;
    adv_mix    = '{12, 0, 40, 2, 25};
    for (int r = 0; r < 32; r++)
      for (int c = 0; c < 8; c++) line_mem[r][c] = 8'h00;
    rd_row  = '0;
    wr_row  = '0;
    col_pos = '0;

    // fresh store, extreme bytes, end of row, end of message, store full
    dir_tab.push_back(typed_row(CMD_ADVANCE, 8'hff, '0, '0, 1'b0, 1'b0, 5'd0));
    dir_tab.push_back(typed_row(CMD_CHAR, 8'h41, 64'h41, '0, 1'b0, 1'b0, 5'd0));
    dir_tab.push_back(typed_row(CMD_CHAR, 8'hff, 64'hff41, '0, 1'b0, 1'b0, 5'd0));
    dir_tab.push_back(typed_row(CMD_CHAR, 8'h80, 64'h80ff41, '0, 1'b0, 1'b0, 5'd0));
    dir_tab.push_back(typed_row(CMD_CHAR, END_OF_ROW, 64'h80ff41, '0, 1'b0, 1'b0, 5'd0));
    dir_tab.push_back(typed_row(CMD_CHAR, 8'h01, 64'h80ff41, 64'h01, 1'b0, 1'b0, 5'd0));
    for (int k = 0; k < 15; k++)
      dir_tab.push_back(typed_row(CMD_CHAR, END_OF_MESSAGE, 64'h80ff41, 64'h01,
                                  1'b0, 1'b1, 5'd0));
    dir_tab.push_back(typed_row(CMD_CHAR, END_OF_ROW, 64'h80ff41, 64'h01, 1'b0, 1'b0, 5'd0));
    dir_tab.push_back(typed_row(CMD_CHAR, 8'h5a, 64'h80ff41, 64'h01, 1'b1, 1'b0, 5'd0));
    dir_tab.push_back(typed_row(CMD_ADVANCE, 8'h00, '0, '0, 1'b0, 1'b0, 5'd2));
    dir_tab.push_back(pred_row(CMD_CHAR, 8'h7e));
    dir_tab.push_back(pred_row(CMD_ADVANCE, 8'h55));

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_tab[i]) send_item(dir_tab[i].it, dir_tab[i].typed, dir_tab[i].view);

    while (sent < RAND_ITEMS) begin
      if (sent % BLOCK_ITEMS == 0) adv_pct = adv_mix[(sent / BLOCK_ITEMS) % 5];
      idle_on = !(sent >= 300 && sent < 450);
      if (sent == 650) hold_req = 1'b1;
      roll = $urandom_range(99);
      it.char_byte = 8'($urandom);
      if (roll < adv_pct) begin
        it.command = CMD_ADVANCE;
      end else if (roll < adv_pct + 4) begin
        it.command = CMD_CHAR;
      end else if (msg_left == 0) begin
        // occasionally run into the next message without a terminator
        it.command = CMD_CHAR;
        if ($urandom_range(99) < 90) it.char_byte = END_OF_MESSAGE;
        else it.char_byte = 8'($urandom_range(255, 1));
        msg_left = $urandom_range(24);
      end else begin
        it.command = CMD_CHAR;
        if ($urandom_range(99) < 8) it.char_byte = END_OF_ROW;
        else it.char_byte = 8'($urandom_range(255, 1));
        msg_left--;
      end
      send_item(it, 1'b0, none);
      sent++;
    end
    item_valid <= 1'b0;
    idle_on = 1'b1;

    while (page_view_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/pmlb_pkg.sv
rtl/core/pmlb_ctrl.sv
rtl/core/pmlb_row_mem.sv
rtl/core/pmlb_out.sv
rtl/core/pager_message_line_buffer.sv
tb/pager_message_line_buffer_tb.sv
